FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared helper macros for the concurrent checks of the statistics unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SWSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SWSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/swsu_pkg.sv
// ---------------------------------------------------------------------------
// swsu_pkg
// shared types and constants of the sliding window statistics unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swsu_pkg;

    localparam int SENSORS_DEF = 8;
    localparam int WINDOW_DEF  = 32;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 136;

    // result field positions in m_tdata
    localparam int M_MEAN_LSB   = 0;
    localparam int M_RMS_LSB    = 16;
    localparam int M_VAR_LSB    = 32;
    localparam int M_RATE_LSB   = 63;
    localparam int M_TREND_LSB  = 80;
    localparam int M_LATEST_LSB = 112;
    localparam int M_N_LSB      = 128;
    localparam int M_N_W        = 6;

    // shared divider operand widths
    localparam int DIV_W = 48;
    localparam int DVS_W = 25;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACC  = 6'b000010,
        ST_PREP = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        DSEL_MEAN  = 2'd0,
        DSEL_MSQ   = 2'd1,
        DSEL_VAR   = 2'd2,
        DSEL_TREND = 2'd3
    } dsel_t;

endpackage

`default_nettype wire

FILE: src/sliding_window_statistics_unit.sv
// ---------------------------------------------------------------------------
// sliding_window_statistics_unit
// per-sensor sliding window mean, rms, variance, step, slope and latest value
// ---------------------------------------------------------------------------
// usage:
//   input beat: s_tuser = sensor number, s_tdata = signed q7.8 sample. the
//   sample joins that sensor's ring of the last WINDOW samples and one result
//   beat follows on m_tdata. a sensor number not below SENSORS is taken and
//   dropped with no result and no state change.
//   steps: the ring walk makes one memory read per held sample (n, the
//   window fill), one step prepares operands, one shared restoring divider
//   runs four divisions, the square root follows and then the hand-off to
//   the output register, which raises m_tvalid.
//   a new input beat is taken only once the last one is through; s_tready
//   is high only while idle.
//   a finished result sits in the output register, so the next input beat
//   is taken while m_tvalid waits on m_tready; if the receiver still stalls
//   when the next result is done, the sequencer holds in its done state.
//   reset: write pointers and fill counts clear at once; the sample memory
//   is not cleared, only slots written since reset are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_statistics_unit #(
    parameter int SENSORS = swsu_pkg::SENSORS_DEF,
    parameter int WINDOW  = swsu_pkg::WINDOW_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [swsu_pkg::S_TDATA_W-1:0] s_tdata,   // sample[15:0]
    input  wire logic [swsu_pkg::S_TUSER_W-1:0] s_tuser,   // sensor_id[2:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // mean[15:0], rms[31:16], variance[62:32], delta[79:63],
    // trend[111:80], latest[127:112], samples_in_window[133:128], zero pad
    output logic [swsu_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SIDW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SW    = $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int DEPTH = SENSORS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = 16 + CW;
    localparam int SQW   = 32 + CW;
    localparam int COEFW = CW + 2;
    localparam int WSW   = 16 + COEFW + CW;
    localparam int DIV_W = swsu_pkg::DIV_W;
    localparam int DVS_W = swsu_pkg::DVS_W;
    localparam int DCW   = $clog2(DIV_W);

    swsu_pkg::state_t state_reg;
    swsu_pkg::dsel_t  dsel_reg;

    // per-sensor ring control
    logic [SW-1:0] wp_reg   [SENSORS];
    logic [CW-1:0] fill_reg [SENSORS];

    // sample memory
    logic [15:0]   mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [15:0]   rd_data_reg;

    // walk control
    logic [SIDW-1:0] sid_reg;
    logic [CW-1:0]   n_reg;
    logic [SW-1:0]   slot_reg;
    logic [CW-1:0]   iss_cnt_reg;
    logic [CW-1:0]   acc_cnt_reg;
    logic            rd_vld_reg;

    // accumulators
    logic signed [SUMW-1:0] sum_reg;
    logic [SQW-1:0]         sumsq_reg;
    logic signed [WSW-1:0]  wsum_reg;
    logic signed [15:0]     last_reg;
    logic signed [15:0]     prev_reg;
    logic [2*CW-1:0]        nn_reg;

    // prepared operands
    logic [DIV_W-1:0] nsq_reg;
    logic [DIV_W-1:0] sum2_reg;
    logic [DIV_W-1:0] tmag_reg;
    logic             tneg_reg;
    logic [DVS_W-1:0] den3_reg;

    // shared divider
    logic             div_run_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [DVS_W:0]   div_rem_reg;
    logic [DIV_W-1:0] div_quo_reg;
    logic [DVS_W-1:0] div_den_reg;

    // square root
    logic [31:0] msq_reg;
    logic [31:0] sq_x_reg;
    logic [17:0] sq_rem_reg;
    logic [15:0] sq_root_reg;
    logic [3:0]  sq_cnt_reg;

    // finished values
    logic [15:0] mean_reg;
    logic [30:0] var_reg;
    logic [31:0] trend_reg;

    // output register
    logic                             m_valid_reg;
    logic [swsu_pkg::M_TDATA_W-1:0]   m_data_reg;

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    logic            in_acc;
    logic            in_ok;
    logic [SIDW-1:0] in_sid;
    logic [SW-1:0]   wp_cur;
    logic [SW-1:0]   wp_new;
    logic [CW-1:0]   fill_cur;
    logic [CW-1:0]   n_new;
    logic [SW-1:0]   start_new;

    assign s_tready = (state_reg == swsu_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_ok    = (int'(s_tuser) < SENSORS);
    assign in_sid   = SIDW'(s_tuser);
    assign wp_cur   = wp_reg[in_sid];
    assign fill_cur = fill_reg[in_sid];
    assign wp_new   = (int'(wp_cur) == WINDOW - 1) ? '0 : SW'(int'(wp_cur) + 1);
    assign n_new    = (int'(fill_cur) == WINDOW) ? fill_cur : CW'(int'(fill_cur) + 1);
    // oldest held slot, wrapped once
    assign start_new = (int'(wp_new) >= int'(n_new))
                     ? SW'(int'(wp_new) - int'(n_new))
                     : SW'(int'(wp_new) + WINDOW - int'(n_new));

    assign mem_we = in_acc && in_ok;
    assign mem_wa = AW'(int'(in_sid) * WINDOW + int'(wp_cur));
    assign mem_ra = AW'(int'(sid_reg) * WINDOW + int'(slot_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= s_tdata;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SENSORS; s++)
            begin
                wp_reg[s]   <= '0;
                fill_reg[s] <= '0;
            end
        end
        else if (mem_we)
        begin
            wp_reg[in_sid]   <= wp_new;
            fill_reg[in_sid] <= n_new;
        end
    end

    // ------------------------------------------------------------------
    // accumulate datapath
    // ------------------------------------------------------------------
    logic                     issue;
    logic signed [31:0]       vv;
    logic signed [COEFW-1:0]  coef;
    logic signed [COEFW+15:0] cv;

    assign issue = (state_reg == swsu_pkg::ST_ACC) && (iss_cnt_reg < n_reg);
    assign vv    = $signed(rd_data_reg) * $signed(rd_data_reg);
    // weight 2i - (n-1) of the i-th oldest sample
    assign coef  = $signed({1'b0, acc_cnt_reg, 1'b0}) - $signed({2'b00, n_reg})
                 + COEFW'(1);
    assign cv    = coef * $signed(rd_data_reg);

    // ------------------------------------------------------------------
    // operand preparation
    // ------------------------------------------------------------------
    logic [CW+SQW-1:0]     nsq_full;
    logic [2*SUMW-1:0]     sum2_full;
    logic signed [DIV_W-1:0] wsum_x;
    logic signed [DIV_W-1:0] tnum;
    logic [3*CW-1:0]       den3_full;

    assign nsq_full  = n_reg * sumsq_reg;
    // full-width square of the signed sum
    assign sum2_full = (2*SUMW)'(sum_reg) * (2*SUMW)'(sum_reg);
    assign wsum_x    = DIV_W'(wsum_reg);
    // times 1536 = 6 * 256
    assign tnum      = (wsum_x <<< 10) + (wsum_x <<< 9);
    assign den3_full = (nn_reg * n_reg) - (3*CW)'(n_reg);

    // ------------------------------------------------------------------
    // shared restoring divider, one quotient bit a cycle once its operands are loaded
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] dvd_sel;
    logic [DVS_W-1:0] dvs_sel;
    logic [DVS_W:0]   div_shift;
    logic [DVS_W+1:0] div_diff;
    logic             div_qbit;
    logic [DVS_W:0]   div_rem_new;
    logic [DIV_W-1:0] div_q_new;
    logic             div_last;

    always_comb
    begin
        unique case (dsel_reg)
            swsu_pkg::DSEL_MEAN:
            begin
                dvd_sel = sum_reg[SUMW-1] ? DIV_W'(-sum_reg) : DIV_W'(sum_reg);
                dvs_sel = DVS_W'(n_reg);
            end
            swsu_pkg::DSEL_MSQ:
            begin
                dvd_sel = DIV_W'(sumsq_reg);
                dvs_sel = DVS_W'(n_reg);
            end
            swsu_pkg::DSEL_VAR:
            begin
                dvd_sel = (nsq_reg >= sum2_reg) ? nsq_reg - sum2_reg : '0;
                dvs_sel = DVS_W'(nn_reg);
            end
            default:
            begin
                dvd_sel = tmag_reg;
                dvs_sel = den3_reg;
            end
        endcase
    end

    assign div_shift   = {div_rem_reg[DVS_W-1:0], div_quo_reg[DIV_W-1]};
    assign div_diff    = {1'b0, div_shift} - {2'b00, div_den_reg};
    assign div_qbit    = !div_diff[DVS_W+1];
    assign div_rem_new = div_qbit ? div_diff[DVS_W:0] : div_shift;
    assign div_q_new   = {div_quo_reg[DIV_W-2:0], div_qbit};
    assign div_last    = (int'(div_cnt_reg) == DIV_W - 1);

    // ------------------------------------------------------------------
    // digit-by-digit square root
    // ------------------------------------------------------------------
    logic [19:0] sq_r;
    logic [19:0] sq_trial;
    logic        sq_ge;

    assign sq_r     = {sq_rem_reg, sq_x_reg[31:30]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_r >= sq_trial);

    // ------------------------------------------------------------------
    // result assembly
    // ------------------------------------------------------------------
    logic [16:0] rate_val;
    logic [swsu_pkg::M_TDATA_W-1:0] res_data;
    logic out_free;

    assign rate_val = (n_reg >= CW'(2)) ? 17'($signed(last_reg) - $signed(prev_reg))
                                        : 17'd0;
    assign res_data = {2'b00, swsu_pkg::M_N_W'(n_reg), last_reg, trend_reg, rate_val,
                       var_reg, sq_root_reg, mean_reg};
    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= swsu_pkg::ST_IDLE;
            dsel_reg    <= swsu_pkg::DSEL_MEAN;
            div_run_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // load a finished result or retire the one taken
            if ((state_reg == swsu_pkg::ST_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg <= issue;
            unique case (state_reg)
                swsu_pkg::ST_IDLE:
                begin
                    if (in_acc && in_ok)
                    begin
                        state_reg <= swsu_pkg::ST_ACC;
                    end
                end
                swsu_pkg::ST_ACC:
                begin
                    if (rd_vld_reg && (acc_cnt_reg == n_reg - CW'(1)))
                    begin
                        state_reg <= swsu_pkg::ST_PREP;
                    end
                end
                swsu_pkg::ST_PREP:
                begin
                    state_reg   <= swsu_pkg::ST_DIV;
                    dsel_reg    <= swsu_pkg::DSEL_MEAN;
                    div_run_reg <= 1'b0;
                end
                swsu_pkg::ST_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        div_run_reg <= 1'b1;
                    end
                    else if (div_last)
                    begin
                        div_run_reg <= 1'b0;
                        if (dsel_reg == swsu_pkg::DSEL_TREND)
                        begin
                            state_reg <= swsu_pkg::ST_SQRT;
                        end
                        else
                        begin
                            dsel_reg <= swsu_pkg::dsel_t'(dsel_reg + 2'd1);
                        end
                    end
                end
                swsu_pkg::ST_SQRT:
                begin
                    if (sq_cnt_reg == 4'd15)
                    begin
                        state_reg <= swsu_pkg::ST_DONE;
                    end
                end
                swsu_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= swsu_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= swsu_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc && in_ok)
        begin
            sid_reg     <= in_sid;
            n_reg       <= n_new;
            slot_reg    <= start_new;
            iss_cnt_reg <= '0;
            acc_cnt_reg <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            wsum_reg    <= '0;
            last_reg    <= '0;
            prev_reg    <= '0;
        end
        if (issue)
        begin
            slot_reg    <= (int'(slot_reg) == WINDOW - 1) ? '0 : SW'(int'(slot_reg) + 1);
            iss_cnt_reg <= iss_cnt_reg + CW'(1);
        end
        if ((state_reg == swsu_pkg::ST_ACC) && rd_vld_reg)
        begin
            sum_reg     <= sum_reg + SUMW'($signed(rd_data_reg));
            sumsq_reg   <= sumsq_reg + SQW'($unsigned(vv));
            wsum_reg    <= wsum_reg + WSW'(cv);
            prev_reg    <= last_reg;
            last_reg    <= $signed(rd_data_reg);
            acc_cnt_reg <= acc_cnt_reg + CW'(1);
        end
        nn_reg <= n_reg * n_reg;
        if (state_reg == swsu_pkg::ST_PREP)
        begin
            nsq_reg  <= DIV_W'(nsq_full);
            sum2_reg <= DIV_W'(sum2_full);
            tneg_reg <= tnum[DIV_W-1];
            tmag_reg <= tnum[DIV_W-1] ? $unsigned(-tnum) : $unsigned(tnum);
            den3_reg <= DVS_W'(den3_full);
        end
        if (state_reg == swsu_pkg::ST_DIV)
        begin
            if (!div_run_reg)
            begin
                div_quo_reg <= dvd_sel;
                div_den_reg <= dvs_sel;
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
            end
            else
            begin
                div_quo_reg <= div_q_new;
                div_rem_reg <= div_rem_new;
                div_cnt_reg <= div_cnt_reg + DCW'(1);
                if (div_last)
                begin
                    unique case (dsel_reg)
                        swsu_pkg::DSEL_MEAN:
                        begin
                            mean_reg <= sum_reg[SUMW-1] ? 16'(~div_q_new[15:0] + 16'd1)
                                                        : div_q_new[15:0];
                        end
                        swsu_pkg::DSEL_MSQ:
                        begin
                            msq_reg <= div_q_new[31:0];
                        end
                        swsu_pkg::DSEL_VAR:
                        begin
                            var_reg <= div_q_new[30:0];
                        end
                        default:
                        begin
                            // truncate toward zero, clamp to 32 bits
                            if (n_reg < CW'(2))
                            begin
                                trend_reg <= '0;
                            end
                            else if (!tneg_reg && (div_q_new > DIV_W'(32'h7FFF_FFFF)))
                            begin
                                trend_reg <= 32'h7FFF_FFFF;
                            end
                            else if (tneg_reg && (div_q_new > DIV_W'(32'h8000_0000)))
                            begin
                                trend_reg <= 32'h8000_0000;
                            end
                            else if (tneg_reg)
                            begin
                                trend_reg <= 32'(~div_q_new[31:0] + 32'd1);
                            end
                            else
                            begin
                                trend_reg <= div_q_new[31:0];
                            end
                            sq_x_reg    <= msq_reg;
                            sq_rem_reg  <= '0;
                            sq_root_reg <= '0;
                            sq_cnt_reg  <= '0;
                        end
                    endcase
                end
            end
        end
        if (state_reg == swsu_pkg::ST_SQRT)
        begin
            sq_x_reg   <= {sq_x_reg[29:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 4'd1;
            if (sq_ge)
            begin
                sq_rem_reg  <= 18'(sq_r - sq_trial);
                sq_root_reg <= {sq_root_reg[14:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_r[17:0];
                sq_root_reg <= {sq_root_reg[14:0], 1'b0};
            end
        end
        if ((state_reg == swsu_pkg::ST_DONE) && out_free)
        begin
            m_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

FILE: src/swsu_checker.sv
// ---------------------------------------------------------------------------
// swsu_checker
// port-level checks of the sliding window statistics unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swsu_checker #(
    parameter int SENSORS = swsu_pkg::SENSORS_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [swsu_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [swsu_pkg::M_TDATA_W-1:0] m_tdata
);

    logic in_beat_ok;
    logic [swsu_pkg::M_N_W-1:0] n_field;

    assign in_beat_ok = s_tvalid && s_tready && (int'(s_tuser) < SENSORS);
    assign n_field    = m_tdata[swsu_pkg::M_N_LSB +: swsu_pkg::M_N_W];

    // stalled result beat holds
    `SWSU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    // a valid input beat starts work, input closes
    `SWSU_ASSERT_NXT(a_busy_after_in, in_beat_ok, !s_tready, "input still open after a valid beat")
    // a result appears only at the end of a busy period
    `SWSU_ASSERT_NOW(a_out_from_work, $rose(m_tvalid), $past(!s_tready), "result without prior work")
    // every result covers at least one sample
    `SWSU_ASSERT_NOW(a_n_nonzero, m_tvalid, n_field != '0, "result with empty window")

endmodule

bind sliding_window_statistics_unit swsu_checker #(
    .SENSORS (SENSORS)
) u_swsu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
